/* design/tprst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprst_pkg
// Shared types and codes for the two-party relay session table.
// ----------------------------------------------------------------------------
package tprst_pkg;

    localparam int ADDR_W    = 64;
    localparam int PORT_W    = 16;
    localparam int IDLE_W    = 16;
    localparam int TIMEOUT_W = 16;
    localparam int ACTION_W  = 2;
    localparam int MASK_W    = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;
    localparam logic [IDLE_W-1:0]    IDLE_MAX      = '1;

    // result action codes
    localparam logic [ACTION_W-1:0] ACT_REFUSE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WAIT    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FORWARD = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

    // input kind
    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // per-slot outcome of the shared compare / age unit
    typedef struct packed {
        logic              hit;
        logic              expired;
        logic [IDLE_W-1:0] idle_next;
    } t_slot_eval;

endpackage

/* design/tprst_slot_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprst_slot_unit
// Shared per-slot unit: address match, saturating idle increment and
// timeout compare for the one slot the sequencer currently reads.
// ----------------------------------------------------------------------------
module tprst_slot_unit (
    input  logic [tprst_pkg::ADDR_W-1:0]    i_slot_addr_hi,
    input  logic [tprst_pkg::ADDR_W-1:0]    i_slot_addr_lo,
    input  logic [tprst_pkg::ADDR_W-1:0]    i_key_addr_hi,
    input  logic [tprst_pkg::ADDR_W-1:0]    i_key_addr_lo,
    input  logic [tprst_pkg::IDLE_W-1:0]    i_idle,
    input  logic [tprst_pkg::TIMEOUT_W-1:0] i_timeout,
    output tprst_pkg::t_slot_eval           o_eval
);

    logic [tprst_pkg::IDLE_W-1:0] idle_inc;

    // idle count sticks at its maximum
    assign idle_inc = (i_idle == tprst_pkg::IDLE_MAX) ? i_idle
                                                      : i_idle + 1'b1;

    always_comb begin
        o_eval.hit       = (i_slot_addr_hi == i_key_addr_hi) &&
                           (i_slot_addr_lo == i_key_addr_lo);
        o_eval.idle_next = idle_inc;
        o_eval.expired   = (idle_inc > i_timeout);
    end

endmodule

/* design/two_party_relay_session_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_party_relay_session_table_unit
// Session table pairing datagram clients: sender lookup, slot allocation,
// peer selection on packets, and idle aging with timeout on ticks.
// ----------------------------------------------------------------------------
// channel   dir  width                 contents
// s_axis    in   tdata 144, tuser 1    arriving packet or one-second tick
// m_axis    out  tdata 152, tuser 2    relay action and destination
// apb       in   32-bit data           timeout_seconds at address 0
//
// One item passes through the sequencer states in order: the accept in
// idle, a scan of every slot in the shared compare/age unit, a resolve of
// the sender slot (packets only), a read of the peer entry (forward only)
// and the hand-off of the result to the output register.
// s_axis_tready is high only while the sequencer is idle; a result waits in
// the output register, and the next item is taken meanwhile. The hand-off
// cycle stretches while the output register is full and m_axis_tready is low.
// Reset (synchronous) frees all slots and sets the timeout to 30.
// ----------------------------------------------------------------------------
module two_party_relay_session_table_unit #(
    parameter int SLOTS = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] src_addr_hi, [127:64] src_addr_lo, [143:128] src_port
    input  logic [143:0] s_axis_tdata,
    // [0] func
    input  logic [0:0]   s_axis_tuser,
    // master stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] dest_slot, [64:1] dest_addr_hi, [128:65] dest_addr_lo,
    // [144:129] dest_port, [145] new_connection, [146] session_started,
    // [148:147] timed_out_mask, [151:149] zero
    output logic [151:0] m_axis_tdata,
    // [1:0] action
    output logic [1:0]   m_axis_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = tprst_pkg::ADDR_W;
    localparam int PW = tprst_pkg::PORT_W;
    localparam int IW = tprst_pkg::IDLE_W;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_RESOLVE = 5'b00100,
        ST_FETCH   = 5'b01000,
        ST_DONE    = 5'b10000
    } t_state;

    typedef struct packed {
        logic [tprst_pkg::ACTION_W-1:0] action;
        logic                           dest_slot;
        logic [AW-1:0]                  addr_hi;
        logic [AW-1:0]                  addr_lo;
        logic [PW-1:0]                  port;
        logic                           new_conn;
        logic                           started;
        logic [tprst_pkg::MASK_W-1:0]   mask;
    } t_result;

    // configuration
    logic [tprst_pkg::TIMEOUT_W-1:0] r_timeout;

    // slot table
    logic [SLOTS-1:0] r_active;
    logic [AW-1:0]    r_addr_hi [SLOTS];
    logic [AW-1:0]    r_addr_lo [SLOTS];
    logic [PW-1:0]    r_port    [SLOTS];
    logic [IW-1:0]    r_idle    [SLOTS];

    // sequencer
    t_state        r_state;
    logic [SW-1:0] r_idx;
    logic          r_func;
    logic [AW-1:0] r_key_hi;
    logic [AW-1:0] r_key_lo;
    logic [PW-1:0] r_key_port;
    logic          r_found;
    logic [SW-1:0] r_me;
    logic          r_ff_found;
    logic [SW-1:0] r_ff;
    logic          r_multi_free;
    logic          r_a0_found;
    logic [SW-1:0] r_a0;
    logic          r_a1_found;
    logic [SW-1:0] r_a1;
    logic [SW-1:0] r_peer;
    t_result       r_res;

    // output register
    logic          r_m_valid;
    t_result       r_m_res;

    logic                  s_xfer;
    logic                  cfg_wr;
    logic [SW-1:0]         rd_idx;
    tprst_pkg::t_slot_eval eval;
    logic                  idx_low2;
    logic                  out_free;

    // resolve-phase decisions
    logic          n_refuse;
    logic [SW-1:0] n_me;
    logic          n_peer_ok;
    logic [SW-1:0] n_peer;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && !paddr[2];
    assign prdata        = paddr[2] ? 32'd0 : {16'd0, r_timeout};
    assign out_free      = !r_m_valid || m_axis_tready;
    assign idx_low2      = ({1'b0, r_idx} < (SW+1)'(2));

    assign rd_idx = (r_state == ST_FETCH) ? r_peer : r_idx;

    tprst_slot_unit u_slot_unit (
        .i_slot_addr_hi (r_addr_hi[rd_idx]),
        .i_slot_addr_lo (r_addr_lo[rd_idx]),
        .i_key_addr_hi  (r_key_hi),
        .i_key_addr_lo  (r_key_lo),
        .i_idle         (r_idle[rd_idx]),
        .i_timeout      (r_timeout),
        .o_eval         (eval)
    );

    always_comb begin
        n_refuse = !r_found && !r_ff_found;
        n_me     = r_found ? r_me : r_ff;
        if (r_found && (r_a0 == r_me)) begin
            n_peer_ok = r_a1_found;
            n_peer    = r_a1;
        end else begin
            n_peer_ok = r_a0_found;
            n_peer    = r_a0;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= tprst_pkg::TIMEOUT_RESET;
        end else if (cfg_wr) begin
            r_timeout <= pwdata[tprst_pkg::TIMEOUT_W-1:0];
        end
    end

    // address and port entries, written on allocation
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESOLVE && !r_found && r_ff_found) begin
            r_addr_hi[r_ff] <= r_key_hi;
            r_addr_lo[r_ff] <= r_key_lo;
            r_port[r_ff]    <= r_key_port;
        end
    end

    // idle counts: aged on a tick, cleared for the sender; every allocation
    // clears the count, so stale counts of inactive entries are never used
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && r_func == tprst_pkg::FUNC_TICK && r_active[r_idx]) begin
            r_idle[r_idx] <= eval.idle_next;
        end else if (r_state == ST_RESOLVE && !n_refuse) begin
            r_idle[n_me] <= '0;
        end
    end

    // sequencer and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_active  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_xfer) begin
                        r_func       <= s_axis_tuser[0];
                        r_key_hi     <= s_axis_tdata[63:0];
                        r_key_lo     <= s_axis_tdata[127:64];
                        r_key_port   <= s_axis_tdata[143:128];
                        r_idx        <= '0;
                        r_found      <= 1'b0;
                        r_ff_found   <= 1'b0;
                        r_multi_free <= 1'b0;
                        r_a0_found   <= 1'b0;
                        r_a1_found   <= 1'b0;
                        r_res        <= '0;
                        r_state      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_func == tprst_pkg::FUNC_TICK) begin
                        if (r_active[r_idx] && eval.expired) begin
                            r_active[r_idx] <= 1'b0;
                            if (idx_low2) begin
                                r_res.mask[r_idx[0]] <= 1'b1;
                            end
                        end
                    end else begin
                        if (r_active[r_idx]) begin
                            if (eval.hit && !r_found) begin
                                r_found <= 1'b1;
                                r_me    <= r_idx;
                            end
                            if (!r_a0_found) begin
                                r_a0_found <= 1'b1;
                                r_a0       <= r_idx;
                            end else if (!r_a1_found) begin
                                r_a1_found <= 1'b1;
                                r_a1       <= r_idx;
                            end
                        end else if (!r_ff_found) begin
                            r_ff_found <= 1'b1;
                            r_ff       <= r_idx;
                        end else begin
                            r_multi_free <= 1'b1;
                        end
                    end
                    if (r_idx == LAST_IDX) begin
                        if (r_func == tprst_pkg::FUNC_TICK) begin
                            r_res.action <= tprst_pkg::ACT_NONE;
                            r_state      <= ST_DONE;
                        end else begin
                            r_state <= ST_RESOLVE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_RESOLVE: begin
                    r_res.addr_hi <= r_key_hi;
                    r_res.addr_lo <= r_key_lo;
                    r_res.port    <= r_key_port;
                    if (n_refuse) begin
                        r_res.action <= tprst_pkg::ACT_REFUSE;
                        r_state      <= ST_DONE;
                    end else begin
                        if (!r_found) begin
                            r_active[r_ff] <= 1'b1;
                            r_res.new_conn <= 1'b1;
                            r_res.started  <= !r_multi_free;
                        end
                        if (n_peer_ok) begin
                            r_peer  <= n_peer;
                            r_state <= ST_FETCH;
                        end else begin
                            r_res.action <= tprst_pkg::ACT_WAIT;
                            r_state      <= ST_DONE;
                        end
                    end
                end
                ST_FETCH: begin
                    r_res.action    <= tprst_pkg::ACT_FORWARD;
                    r_res.dest_slot <= r_peer[0];
                    r_res.addr_hi   <= r_addr_hi[rd_idx];
                    r_res.addr_lo   <= r_addr_lo[rd_idx];
                    r_res.port      <= r_port[rd_idx];
                    r_state         <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_m_res <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.action;
    assign m_axis_tdata  = {3'd0, r_m_res.mask, r_m_res.started, r_m_res.new_conn,
                            r_m_res.port, r_m_res.addr_lo, r_m_res.addr_hi,
                            r_m_res.dest_slot};

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the relay session table. Packets and ticks go in
// on the input stream. A behavioral copy of the slot table predicts every
// relay action. Results are checked in order with random stalls on both
// streams. The timeout register is changed between phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NSLOT         = 2;
    localparam int SETTLE_CYCLES = 2 * NSLOT + 8;
    localparam int LIMIT_CYCLES  = 3_000_000;

    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_SPARE   = 3'd4;   // unmapped, writes are dropped

    typedef struct packed {
        logic                             hold;   // marker only: sender waits for all results
        logic                             func;
        logic [tprst_pkg::ADDR_W-1:0]     hi;
        logic [tprst_pkg::ADDR_W-1:0]     lo;
        logic [tprst_pkg::PORT_W-1:0]     port;
    } t_relay_item;

    typedef struct packed {
        logic [tprst_pkg::ACTION_W-1:0]   action;
        logic                             dest_slot;
        logic [tprst_pkg::ADDR_W-1:0]     hi;
        logic [tprst_pkg::ADDR_W-1:0]     lo;
        logic [tprst_pkg::PORT_W-1:0]     port;
        logic                             new_conn;
        logic                             started;
        logic [tprst_pkg::MASK_W-1:0]     mask;
    } t_relay_result;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [63:0] src_addr_hi, [127:64] src_addr_lo, [143:128] src_port
    logic [143:0] s_axis_tdata  = '0;
    // [0] func
    logic [0:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [0] dest_slot, [64:1] dest_addr_hi, [128:65] dest_addr_lo,
    // [144:129] dest_port, [145] new_connection, [146] session_started,
    // [148:147] timed_out_mask
    logic [151:0] m_axis_tdata;
    // [1:0] action
    logic [1:0]   m_axis_tuser;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [2:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;

    // behavioral slot table
    logic [NSLOT-1:0]                sess_live  = '0;
    logic [tprst_pkg::ADDR_W-1:0]    sess_hi    [NSLOT];
    logic [tprst_pkg::ADDR_W-1:0]    sess_lo    [NSLOT];
    logic [tprst_pkg::PORT_W-1:0]    sess_port  [NSLOT];
    logic [tprst_pkg::IDLE_W-1:0]    sess_idle  [NSLOT];
    logic [tprst_pkg::TIMEOUT_W-1:0] idle_limit = tprst_pkg::TIMEOUT_RESET;

    t_relay_item   arrivals [$];
    t_relay_result pending_actions [$];
    t_relay_item   item_on_bus;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            error_total   = 0;
    int            cycle_count   = 0;

    two_party_relay_session_table_unit #(
        .SLOTS(NSLOT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int lowest_free_slot();
        for (int s = 0; s < NSLOT; s++) begin
            if (!sess_live[s]) return s;
        end
        return -1;
    endfunction

    function automatic t_relay_result session_table_step(t_relay_item it);
        t_relay_result r;
        int            own;
        int            peer;
        r = '0;
        if (it.func == tprst_pkg::FUNC_TICK) begin
            r.action = tprst_pkg::ACT_NONE;
            for (int s = 0; s < NSLOT; s++) begin
                if (sess_live[s]) begin
                    if (sess_idle[s] != tprst_pkg::IDLE_MAX)
                        sess_idle[s] = sess_idle[s] + 1'b1;
                    if (sess_idle[s] > idle_limit) begin
                        sess_live[s] = 1'b0;
                        if (s < tprst_pkg::MASK_W) r.mask[s] = 1'b1;
                    end
                end
            end
            return r;
        end
        own  = -1;
        peer = -1;
        // the port takes no part in the lookup
        for (int s = 0; s < NSLOT; s++) begin
            if (own < 0 && sess_live[s] && sess_hi[s] == it.hi && sess_lo[s] == it.lo)
                own = s;
        end
        if (own < 0) begin
            own = lowest_free_slot();
            if (own < 0) begin
                r.action = tprst_pkg::ACT_REFUSE;
                r.hi     = it.hi;
                r.lo     = it.lo;
                r.port   = it.port;
                return r;
            end
            sess_live[own] = 1'b1;
            sess_hi[own]   = it.hi;
            sess_lo[own]   = it.lo;
            sess_port[own] = it.port;
            r.new_conn     = 1'b1;
            r.started      = (lowest_free_slot() < 0);
        end
        sess_idle[own] = '0;
        for (int s = 0; s < NSLOT; s++) begin
            if (peer < 0 && s != own && sess_live[s]) peer = s;
        end
        if (peer < 0) begin
            r.action = tprst_pkg::ACT_WAIT;
            r.hi     = it.hi;
            r.lo     = it.lo;
            r.port   = it.port;
        end else begin
            r.action    = tprst_pkg::ACT_FORWARD;
            r.dest_slot = peer[0];
            r.hi        = sess_hi[peer];
            r.lo        = sess_lo[peer];
            r.port      = sess_port[peer];
        end
        return r;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_total++;
        end
    endfunction

    function automatic logic [tprst_pkg::ADDR_W-1:0] rand_addr();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [tprst_pkg::PORT_W-1:0] rand_port();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return tprst_pkg::PORT_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic void add_packet(logic [tprst_pkg::ADDR_W-1:0] hi,
                                       logic [tprst_pkg::ADDR_W-1:0] lo,
                                       logic [tprst_pkg::PORT_W-1:0] port);
        t_relay_item it;
        it      = '0;
        it.func = tprst_pkg::FUNC_PACKET;
        it.hi   = hi;
        it.lo   = lo;
        it.port = port;
        arrivals.push_back(it);
    endfunction

    // address and port bits of a tick are don't-care, so they are randomized
    function automatic void add_tick();
        t_relay_item it;
        it      = '0;
        it.func = tprst_pkg::FUNC_TICK;
        it.hi   = {$urandom(), $urandom()};
        it.lo   = {$urandom(), $urandom()};
        it.port = tprst_pkg::PORT_W'($urandom_range(65535));
        arrivals.push_back(it);
    endfunction

    function automatic void add_hold();
        t_relay_item it;
        it      = '0;
        it.hold = 1'b1;
        arrivals.push_back(it);
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_TIMEOUT) idle_limit = data[tprst_pkg::TIMEOUT_W-1:0];
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (arrivals.size() != 0 || s_axis_tvalid || pending_actions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // a few clients compete for the two slots; tick runs around the timeout
    // make slots expire, stray addresses add noise
    task automatic queue_random_phase(input int n_items, input int tick_pct,
                                      input int run_base);
        logic [tprst_pkg::ADDR_W-1:0] pool_hi [4];
        logic [tprst_pkg::ADDR_W-1:0] pool_lo [4];
        int                           left;
        int                           pick;
        int                           run;
        foreach (pool_hi[k]) begin
            pool_hi[k] = rand_addr();
            pool_lo[k] = rand_addr();
        end
        pool_hi[3] = pool_hi[0];   // same upper half, different client
        left = n_items;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                run = run_base + $urandom_range(0, 3);
                if (run > left) run = left;
                repeat (run) add_tick();
                left -= run;
            end else if (pick < 3 + tick_pct) begin
                add_tick();
                left--;
            end else if (pick < 96) begin
                pick = $urandom_range(3);
                add_packet(pool_hi[pick], pool_lo[pick], rand_port());
                left--;
            end else begin
                add_packet(rand_addr(), rand_addr(), rand_port());
                left--;
            end
            if ($urandom_range(199) == 0) add_hold();
        end
    endtask

    task automatic run_phase(input int limit, input int tick_pct,
                             input int send_pct, input int recv_pct);
        wait_idle();
        apb_write(REG_TIMEOUT, 32'(limit));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_random_phase(325, tick_pct, (limit == 65535) ? 0 : limit);
    endtask

    // input stream driver
    always @(posedge i_clk) begin : stim_drive
        t_relay_item nxt;
        logic        launch;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                pending_actions.push_back(session_table_step(item_on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                launch = 1'b0;
                if (arrivals.size() != 0 && arrivals[0].hold && pending_actions.size() == 0)
                    arrivals.delete(0);
                if (arrivals.size() != 0 && !arrivals[0].hold &&
                        $urandom_range(99) >= send_idle_pct) begin
                    nxt         = arrivals[0];
                    arrivals.delete(0);
                    launch      = 1'b1;
                    item_on_bus = nxt;
                    s_axis_tdata <= {nxt.port, nxt.lo, nxt.hi};
                    s_axis_tuser <= nxt.func;
                end
                s_axis_tvalid <= launch;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin : result_check
        t_relay_result want;
        t_relay_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.action    = m_axis_tuser;
            got.dest_slot = m_axis_tdata[0];
            got.hi        = m_axis_tdata[64:1];
            got.lo        = m_axis_tdata[128:65];
            got.port      = m_axis_tdata[144:129];
            got.new_conn  = m_axis_tdata[145];
            got.started   = m_axis_tdata[146];
            got.mask      = m_axis_tdata[148:147];
            if (pending_actions.size() == 0) begin
                $error("result transfer with none outstanding, action %0d", got.action);
                error_total++;
            end else begin
                want = pending_actions.pop_front();
                compare_field("action", 64'(want.action), 64'(got.action));
                compare_field("dest_slot", 64'(want.dest_slot), 64'(got.dest_slot));
                compare_field("dest_addr_hi", want.hi, got.hi);
                compare_field("dest_addr_lo", want.lo, got.lo);
                compare_field("dest_port", 64'(want.port), 64'(got.port));
                compare_field("new_connection", 64'(want.new_conn), 64'(got.new_conn));
                compare_field("session_started", 64'(want.started), 64'(got.started));
                compare_field("timed_out_mask", 64'(want.mask), 64'(got.mask));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("two_party_relay_session_table_unit test failed");
            $finish;
        end
    end

    initial begin : run_sequence
        logic [tprst_pkg::ADDR_W-1:0] mixed_hi;
        logic [tprst_pkg::ADDR_W-1:0] mixed_lo;
        mixed_hi = {32{2'b01}};
        mixed_lo = {32{2'b10}};
        foreach (sess_idle[s]) sess_idle[s] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 86;
        // reset timeout: join, rejoin from a new port, pair up, refuse a third
        add_tick();
        add_packet('1, '1, '1);
        add_packet('1, '1, '0);
        add_packet('0, '0, '0);
        add_packet('1, '0, 16'd1);
        add_hold();
        add_packet('1, '1, 16'd1234);
        add_tick();
        wait_idle();
        apb_write(REG_SPARE, 32'd7);
        apb_write(REG_TIMEOUT, 32'd0);
        // zero timeout: the first tick after a packet frees the slot
        add_tick();
        add_packet(mixed_hi, mixed_lo, 16'hAAAA);
        add_packet(mixed_lo, mixed_hi, 16'h5555);
        add_packet(mixed_hi, mixed_lo, 16'h0F0F);
        add_tick();
        add_packet('0, '0, '1);
        add_tick();

        run_phase(1, 25, 7, 86);
        run_phase(30, 30, 7, 86);
        run_phase(3, 25, 86, 7);
        run_phase(0, 30, 86, 7);
        wait_idle();
        apb_write(REG_SPARE, 32'd0);
        run_phase(65535, 20, 0, 0);
        run_phase(7, 25, 0, 0);

        wait_idle();
        if (error_total == 0) begin
            $display("two_party_relay_session_table_unit test passed");
        end else begin
            $display("two_party_relay_session_table_unit test failed");
        end
        $finish;
    end

endmodule
